[hw/rtl/asrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ascending sorter package
// Shared types and constants for the insertion-chain sorter.
// ----------------------------------------------------------------------------
package asrt_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic signed [DataWidth-1:0] data_t;

  typedef struct packed {
    data_t value;
    logic  last;
  } in_req_t;

  typedef struct packed {
    data_t sorted_value;
    logic  final_res;
  } out_rsp_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    StLoad  = 1'b0,
    StDrain = 1'b1
  } state_e;

endpackage
`default_nettype wire

[hw/rtl/ascending_sorter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ascending sorter
// Loads a set of signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
// Usage: send the set on the input channel, one request per cycle, with last
// set on the final element. Each element is inserted into a chain of DEPTH
// cells that stays sorted at all times. Elements beyond DEPTH are dropped, but
// a dropped request flagged last still ends the set. The cycle after the last
// request is accepted, the output channel presents the smallest element;
// every accepted response shifts the chain by one cell, giving one result per
// cycle while the receiver is ready. The final result has final_res set. A
// stalled receiver simply holds the chain. While a set is draining,
// in_ready_o is low; a new set may start the cycle after the final response
// is taken. Reset empties the chain and returns the block to loading.
// ----------------------------------------------------------------------------
module ascending_sorter #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire asrt_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output asrt_pkg::out_rsp_t      out_rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  asrt_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  asrt_pkg::cell_ctrl_t ctrl;
  logic                 in_fire, out_fire, room;

  asrt_pkg::data_t      cell_value [DEPTH];
  logic [DEPTH-1:0]     cell_valid;
  logic [DEPTH-1:0]     cell_disp;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign room     = count_q < CntW'(DEPTH);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    case (state_q)
      asrt_pkg::StLoad: begin
        if (in_fire) begin
          if (in_req_i.last) begin
            state_d = asrt_pkg::StDrain;
            count_d = '0;
          end else if (room) begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      asrt_pkg::StDrain: begin
        if (out_fire && out_rsp_o.final_res) begin
          state_d = asrt_pkg::StLoad;
        end
      end
      default: begin
        state_d = asrt_pkg::StLoad;
      end
    endcase
  end

  // Ready is constant within each state, so the cell commands follow the
  // other side's handshake signal directly.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctrl        = '0;
    case (state_q)
      asrt_pkg::StLoad: begin
        in_ready_o  = 1'b1;
        ctrl.insert = in_valid_i && room;
      end
      asrt_pkg::StDrain: begin
        out_valid_o = 1'b1;
        ctrl.shift  = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asrt_pkg::StLoad;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    asrt_pkg::data_t left_value, right_value;
    logic            left_valid, left_disp, right_valid;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_valid = 1'b0;
      assign left_disp  = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_disp  = cell_disp[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_next
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    asrt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_value_i   (in_req_i.value),
      .left_disp_i   (left_disp),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .right_value_i (right_value),
      .right_valid_i (right_valid),
      .disp_o        (cell_disp[i]),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i])
    );
  end

  // The head cell always holds the smallest element; the set ends when the
  // second cell is empty.
  assign out_rsp_o.sorted_value = cell_value[0];
  assign out_rsp_o.final_res    = !cell_valid[1];

  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asrt_pkg::StLoad) |-> ($countones(cell_valid) == int'(count_q)))
    else $error("element count disagrees with occupied cells");

  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cell_valid[0])
    else $error("response offered from an empty head cell");

  a_empty_after_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_rsp_o.final_res) |=> (cell_valid == '0))
    else $error("chain not empty after final response");

  a_ordered_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_rsp_o.final_res) |=> (cell_value[0] >= $past(cell_value[0])))
    else $error("responses not in ascending order");

endmodule
`default_nettype wire

[hw/rtl/asrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorter chain cell
// Holds one element; on insert it keeps its value, takes the new value or
// takes its left neighbor's value; on drain it takes its right neighbor's.
// ----------------------------------------------------------------------------
module asrt_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire asrt_pkg::cell_ctrl_t  ctrl_i,
  input  wire asrt_pkg::data_t       new_value_i,
  input  wire logic                  left_disp_i,
  input  wire asrt_pkg::data_t       left_value_i,
  input  wire logic                  left_valid_i,
  input  wire asrt_pkg::data_t       right_value_i,
  input  wire logic                  right_valid_i,
  output logic                       disp_o,
  output asrt_pkg::data_t            value_o,
  output logic                       valid_o
);

  asrt_pkg::data_t value_q, value_d;
  logic            valid_q, valid_d;
  logic            disp;

  // An empty cell counts as larger than any value.
  assign disp = !valid_q || (new_value_i < value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.insert && disp) begin
      if (left_disp_i) begin
        value_d = left_value_i;
        valid_d = left_valid_i;
      end else begin
        value_d = new_value_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign disp_o  = disp;
  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire
